// ===== rtl/ble_pkg.sv =====
package ble_pkg;

  // Default number of list entries held in the store.
  localparam int unsigned DepthDefault = 32;

  // Width of one list entry and of the command operand.
  localparam int unsigned OpW = 32;

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_CLEAR      = 3'd5,
    CMD_READ_FIRST = 3'd6,
    CMD_READ_LAST  = 3'd7
  } cmd_e;

endpackage

// ===== rtl/ble_cmd_if.sv =====
interface ble_cmd_if;

  // Command channel: one item per command.
  logic                             valid;
  logic                             ready;
  ble_pkg::cmd_e                    command;
  logic signed [ble_pkg::OpW-1:0]   operand;

  modport source (output valid, output command, output operand, input ready);
  modport sink   (input valid, input command, input operand, output ready);

endinterface

// ===== rtl/ble_res_if.sv =====
interface ble_res_if;

  // Result channel: one item per entry read out or per status.
  logic                             valid;
  logic                             ready;
  logic signed [ble_pkg::OpW-1:0]   item;
  logic                             has_item;
  logic                             last_of_run;
  logic                             dropped;

  modport source (output valid, output item, output has_item, output last_of_run,
                  output dropped, input ready);
  modport sink   (input valid, input item, input has_item, input last_of_run,
                  input dropped, output ready);

endinterface

// ===== rtl/bounded_list_deque_engine.sv =====
// Push, pop and clear: the status item passes through S_EXEC and S_ST into
// the output register, S_ST waiting until that register is free, and the next
// command item is taken once the engine is back in S_IDLE. Reads of n entries:
// one item per cycle while the output keeps draining, from the single read
// port of the entry store; remove walks all entries, then registers its status
// item. Reset clears the head index, the entry count and all control state;
// the entry store is not cleared, so no clearing pass follows reset.
module bounded_list_deque_engine #(
  parameter int unsigned DEPTH = ble_pkg::DepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ble_cmd_if.sink    cmd_i,
  ble_res_if.source  res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OpW = ble_pkg::OpW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_RM   = 5'b01000,
    S_ST   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  ble_pkg::cmd_e     cmd_q, cmd_d;
  logic [OpW-1:0]    opnd_q, opnd_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     walk_q, walk_d;
  logic [CW-1:0]     kept_q, kept_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     first_q, first_d;
  logic              pend_q, pend_d;
  logic              drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  logic [OpW-1:0]    out_item_q, out_item_d;
  logic              out_has_q, out_has_d;
  logic              out_last_q, out_last_d;
  logic              out_drop_q, out_drop_d;

  logic              st_rd_en;
  logic [AW-1:0]     st_rd_pos;
  logic [OpW-1:0]    st_rd_data;
  logic              st_wr_en;
  logic [AW-1:0]     st_wr_pos;
  logic [OpW-1:0]    st_wr_data;

  // Entry store with head-relative addressing. Remove writes at the kept
  // position, which always trails the position being read, so the two ports
  // never meet on one entry and no forwarding is needed.
  ble_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .rd_en_i   (st_rd_en),
    .rd_pos_i  (st_rd_pos),
    .rd_data_o (st_rd_data),
    .wr_en_i   (st_wr_en),
    .wr_pos_i  (st_wr_pos),
    .wr_data_i (st_wr_data)
  );

  assign cmd_i.ready = (state_q == S_IDLE);

  // Sequencer and output register.
  always_comb begin
    logic          out_free;
    logic          take;
    logic          issue;
    logic [CW-1:0] n_sel;

    state_d     = state_q;
    cmd_d       = cmd_q;
    opnd_d      = opnd_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    walk_d      = walk_q;
    kept_d      = kept_q;
    n_d         = n_q;
    first_d     = first_q;
    pend_d      = pend_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    st_rd_en    = 1'b0;
    st_rd_pos   = '0;
    st_wr_en    = 1'b0;
    st_wr_pos   = '0;
    st_wr_data  = opnd_q;
    take        = 1'b0;
    issue       = 1'b0;
    n_sel       = '0;

    // The output register frees up when the waiting item is taken.
    out_free = !out_valid_q || res_o.ready;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.command;
          opnd_d  = cmd_i.operand;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        drop_d  = 1'b0;
        walk_d  = '0;
        kept_d  = '0;
        pend_d  = 1'b0;
        state_d = S_ST;
        case (cmd_q)
          ble_pkg::CMD_PUSH_FRONT: begin
            if (cnt_q == DepthC) begin
              drop_d = 1'b1;
            end else begin
              // The slot just before the head becomes the new head.
              st_wr_en  = 1'b1;
              st_wr_pos = LastSlot;
              head_d    = (head_q == '0) ? LastSlot : head_q - AW'(1);
              cnt_d     = cnt_q + CW'(1);
            end
          end
          ble_pkg::CMD_PUSH_BACK: begin
            if (cnt_q == DepthC) begin
              drop_d = 1'b1;
            end else begin
              st_wr_en  = 1'b1;
              st_wr_pos = AW'(cnt_q);
              cnt_d     = cnt_q + CW'(1);
            end
          end
          ble_pkg::CMD_POP_FRONT: begin
            if (cnt_q != '0) begin
              head_d = (head_q == LastSlot) ? '0 : head_q + AW'(1);
              cnt_d  = cnt_q - CW'(1);
            end
          end
          ble_pkg::CMD_POP_BACK: begin
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          ble_pkg::CMD_REMOVE: begin
            state_d = S_RM;
          end
          ble_pkg::CMD_CLEAR: begin
            cnt_d  = '0;
            head_d = '0;
          end
          default: begin
            // Reads: a negative count or one at least the fill reads everything.
            if (opnd_q[OpW-1] || (opnd_q >= OpW'(cnt_q))) begin
              n_sel = cnt_q;
            end else begin
              n_sel = opnd_q[CW-1:0];
            end
            n_d     = n_sel;
            first_d = (cmd_q == ble_pkg::CMD_READ_FIRST) ? '0 : cnt_q - n_sel;
            // An empty read gives the same item as a status without a drop.
            if (n_sel != '0) begin
              state_d = S_RD;
            end
          end
        endcase
      end

      S_RD: begin
        // Issue one read a cycle while the output keeps draining.
        take  = pend_q && out_free;
        issue = (walk_q < n_q) && (!pend_q || take);
        if (take) begin
          out_valid_d = 1'b1;
          out_item_d  = st_rd_data;
          out_has_d   = 1'b1;
          out_last_d  = (walk_q == n_q);
          out_drop_d  = 1'b0;
        end
        if (issue) begin
          st_rd_en  = 1'b1;
          st_rd_pos = AW'(first_q + walk_q);
          walk_d    = walk_q + CW'(1);
          pend_d    = 1'b1;
        end else if (take) begin
          pend_d = 1'b0;
        end
        if (take && (walk_q == n_q)) begin
          state_d = S_IDLE;
        end
      end

      S_RM: begin
        // Compact the kept entries towards the front, preserving their order.
        issue = (walk_q < cnt_q);
        if (pend_q && (st_rd_data != opnd_q)) begin
          st_wr_en   = 1'b1;
          st_wr_pos  = AW'(kept_q);
          st_wr_data = st_rd_data;
          kept_d     = kept_q + CW'(1);
        end
        if (issue) begin
          st_rd_en  = 1'b1;
          st_rd_pos = AW'(walk_q);
          walk_d    = walk_q + CW'(1);
        end
        pend_d = issue;
        if (!issue && !pend_q) begin
          cnt_d   = kept_q;
          state_d = S_ST;
        end
      end

      S_ST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '0;
          out_has_d   = 1'b0;
          out_last_d  = 1'b1;
          out_drop_d  = drop_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      walk_q      <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      walk_q      <= walk_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    opnd_q     <= opnd_d;
    n_q        <= n_d;
    first_q    <= first_d;
    drop_q     <= drop_d;
    out_item_q <= out_item_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.item        = out_item_q;
  assign res_o.has_item    = out_has_q;
  assign res_o.last_of_run = out_last_q;
  assign res_o.dropped     = out_drop_q;

  // The fill never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count exceeds depth");

  // The head always points inside the store.
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < (AW+1)'(DEPTH))
    else $error("head index outside store");

  // Read data is only pending during a walk.
  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_RD || state_q == S_RM))
    else $error("pending read outside a walk");

  // A read-out never modifies the store.
  a_rd_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> !st_wr_en)
    else $error("store written during read-out");

endmodule

// ===== rtl/ble_store.sv =====
module ble_store #(
  parameter int unsigned DEPTH = ble_pkg::DepthDefault,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic [AW-1:0]           head_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_pos_i,
  output logic [ble_pkg::OpW-1:0] rd_data_o,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_pos_i,
  input  logic [ble_pkg::OpW-1:0] wr_data_i
);

  localparam logic [AW:0] DepthW = (AW+1)'(DEPTH);

  logic [ble_pkg::OpW-1:0] mem_q [DEPTH];
  logic [ble_pkg::OpW-1:0] rd_data_q;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  // Map a list position to a physical slot, wrapping at the store depth.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AW-1:0];
  endfunction

  assign rd_addr = slot_of(head_i, rd_pos_i);
  assign wr_addr = slot_of(head_i, wr_pos_i);

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sim/tb_bounded_list_deque_engine.sv =====
module tb_bounded_list_deque_engine;
  import ble_pkg::*;

  localparam int unsigned Depth     = DepthDefault;
  localparam int          IdleLimit = 2000;
  localparam int          RandItems = 236;

  // One command item waiting for the driver; hold_for_idle makes the driver
  // wait until every expected result has come before offering it.
  typedef struct {
    cmd_e                  command;
    logic signed [OpW-1:0] operand;
    bit                    hold_for_idle;
  } cmd_item_t;

  typedef struct packed {
    logic signed [OpW-1:0] item;
    logic                  has_item;
    logic                  last_of_run;
    logic                  dropped;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ble_cmd_if cmd_ch ();
  ble_res_if res_ch ();

  bounded_list_deque_engine #(
    .DEPTH (Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  // Clock with a period of 8 time units.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_item_t             pending_cmds[$];
  reply_t                expected_replies[$];
  logic signed [OpW-1:0] shadow_store[Depth];
  int                    shadow_head  = 0;
  int                    shadow_count = 0;
  logic signed [OpW-1:0] value_pool[6];
  bit                    cmd_taken    = 1'b0;
  int                    idle_cycles  = 0;
  int                    error_count  = 0;
  int                    burst_left   = 4;
  int                    gap_left     = 0;
  int                    stall_mode   = 0;
  int                    stall_phase  = 0;
  int                    stall_tick   = 0;

  // Updates the shadow deque for one accepted command and queues the result
  // items it must produce.
  function automatic void apply_command(cmd_e cmd, logic signed [OpW-1:0] opnd);
    logic signed [OpW-1:0] v;
    int                    kept;
    int                    n;
    int                    first;
    bit                    is_read;
    bit                    full_drop;
    full_drop = 1'b0;
    is_read   = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_count >= Depth) begin
          full_drop = 1'b1;
        end else begin
          shadow_head = (shadow_head + Depth - 1) % Depth;
          shadow_store[shadow_head] = opnd;
          shadow_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_count >= Depth) begin
          full_drop = 1'b1;
        end else begin
          shadow_store[(shadow_head + shadow_count) % Depth] = opnd;
          shadow_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count > 0) begin
          shadow_head = (shadow_head + 1) % Depth;
          shadow_count--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count > 0) shadow_count--;
      end
      CMD_REMOVE: begin
        // Compact the survivors towards the front, keeping their order.
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          v = shadow_store[(shadow_head + i) % Depth];
          if (v != opnd) begin
            shadow_store[(shadow_head + kept) % Depth] = v;
            kept++;
          end
        end
        shadow_count = kept;
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_head  = 0;
      end
      default: begin
        // A negative count or one at least the list length reads everything.
        is_read = 1'b1;
        if (opnd < 0 || opnd >= shadow_count) n = shadow_count;
        else n = opnd;
        if (n == 0) begin
          expected_replies.push_back('{item: '0, has_item: 1'b0, last_of_run: 1'b1,
                                       dropped: 1'b0});
        end else begin
          first = (cmd == CMD_READ_FIRST) ? 0 : shadow_count - n;
          for (int k = 0; k < n; k++) begin
            expected_replies.push_back('{
              item: shadow_store[(shadow_head + first + k) % Depth],
              has_item: 1'b1, last_of_run: (k + 1 == n), dropped: 1'b0});
          end
        end
      end
    endcase
    if (!is_read) begin
      expected_replies.push_back('{item: '0, has_item: 1'b0, last_of_run: 1'b1,
                                   dropped: full_drop});
    end
  endfunction

  task automatic add_cmd(cmd_e cmd, logic signed [OpW-1:0] opnd, bit hold = 1'b0);
    pending_cmds.push_back('{command: cmd, operand: opnd, hold_for_idle: hold});
  endtask

  // Values are often drawn from a small pool so that remove finds matches.
  function automatic logic signed [OpW-1:0] random_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic signed [OpW-1:0] random_count();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return $urandom;
    if (sel == 1) return -$urandom_range(1, 5);
    return $urandom_range(0, Depth + 2);
  endfunction

  // Driver: offers command items at the falling edge, in bursts with gaps.
  always @(negedge clk_i) begin
    cmd_item_t nxt;
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_taken) begin
      // The offered item has not been taken yet, so it stays on the bus.
    end else if (gap_left > 0) begin
      gap_left--;
      cmd_ch.valid <= 1'b0;
    end else if (pending_cmds.size() > 0 &&
                 !(pending_cmds[0].hold_for_idle && expected_replies.size() > 0)) begin
      nxt = pending_cmds.pop_front();
      cmd_ch.valid   <= 1'b1;
      cmd_ch.command <= nxt.command;
      cmd_ch.operand <= nxt.operand;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Receiver: ready follows a stall pattern that changes from phase to phase.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_phase = $urandom_range(10, 60);
      end
      stall_phase--;
      stall_tick++;
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= $urandom_range(0, 1);
        2:       res_ch.ready <= (stall_tick % 4 == 0);
        default: res_ch.ready <= (stall_tick % 3 != 0);
      endcase
    end
  end

  // Monitor: predicts on each accepted command and checks each accepted result.
  always @(posedge clk_i) begin
    reply_t want;
    bit     res_fire;
    bit     cmd_fire;
    if (rst_ni) begin
      cmd_fire = cmd_ch.valid && cmd_ch.ready;
      res_fire = res_ch.valid && res_ch.ready;
      cmd_taken <= cmd_fire;
      if (cmd_fire) apply_command(cmd_ch.command, cmd_ch.operand);
      if (res_fire) begin
        if (expected_replies.size() == 0) begin
          $error("Result item with none expected: item %0d has_item %0b",
                 res_ch.item, res_ch.has_item);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (res_ch.item !== want.item) begin
            $error("item: expected %0d, got %0d", want.item, res_ch.item);
            error_count++;
          end
          if (res_ch.has_item !== want.has_item) begin
            $error("has_item: expected %0b, got %0b", want.has_item, res_ch.has_item);
            error_count++;
          end
          if (res_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   res_ch.last_of_run);
            error_count++;
          end
          if (res_ch.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, res_ch.dropped);
            error_count++;
          end
        end
      end
      idle_cycles <= (cmd_fire || res_fire) ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int generated;
    int sel;
    int len;
    cmd_e cmd;
    rst_ni         = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_CLEAR;
    cmd_ch.operand = '0;
    res_ch.ready   = 1'b0;
    value_pool = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd7, -32'sd7};

    // Directed part: empty-list cases, extreme values, every read form.
    add_cmd(CMD_READ_FIRST, -1);
    add_cmd(CMD_POP_FRONT, 0);
    add_cmd(CMD_POP_BACK, 0);
    add_cmd(CMD_REMOVE, 5);
    add_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
    add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
    add_cmd(CMD_PUSH_BACK, -1);
    add_cmd(CMD_PUSH_FRONT, 0);
    add_cmd(CMD_PUSH_BACK, -1);
    add_cmd(CMD_READ_FIRST, 2);
    add_cmd(CMD_READ_LAST, 2);
    add_cmd(CMD_READ_FIRST, -1);
    add_cmd(CMD_READ_LAST, 0);
    add_cmd(CMD_READ_FIRST, 100);
    add_cmd(CMD_READ_LAST, 32'sh8000_0000);
    add_cmd(CMD_REMOVE, -1);
    add_cmd(CMD_REMOVE, 12345);
    add_cmd(CMD_READ_LAST, 3);
    add_cmd(CMD_POP_FRONT, 0);
    add_cmd(CMD_POP_BACK, 0);
    add_cmd(CMD_READ_FIRST, 1);
    add_cmd(CMD_CLEAR, 0);
    add_cmd(CMD_READ_LAST, 7);
    add_cmd(CMD_PUSH_FRONT, 32'sh5A5A_A5A5, 1'b1);

    // Random part: runs that fill the store past full, and mixed runs.
    generated = 0;
    while (generated < RandItems) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < Depth + 2; i++) begin
          add_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value(),
                  i == 0 && $urandom_range(0, 3) == 0);
        end
        add_cmd(CMD_READ_LAST, random_count());
        add_cmd(CMD_REMOVE, value_pool[$urandom_range(0, 5)]);
        add_cmd(CMD_READ_FIRST, -1);
        generated += Depth + 5;
      end else begin
        len = $urandom_range(6, 16);
        for (int i = 0; i < len; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 22)      cmd = CMD_PUSH_FRONT;
          else if (sel < 45) cmd = CMD_PUSH_BACK;
          else if (sel < 53) cmd = CMD_POP_FRONT;
          else if (sel < 61) cmd = CMD_POP_BACK;
          else if (sel < 71) cmd = CMD_REMOVE;
          else if (sel < 74) cmd = CMD_CLEAR;
          else if (sel < 87) cmd = CMD_READ_FIRST;
          else               cmd = CMD_READ_LAST;
          add_cmd(cmd,
                  (cmd == CMD_READ_FIRST || cmd == CMD_READ_LAST) ? random_count()
                                                                  : random_value(),
                  i == 0 && $urandom_range(0, 7) == 0);
        end
        generated += len;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all items to be taken and all results to arrive, then linger.
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_replies.size() != 0);
    repeat (40) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
